/* rtl/ppp_pkg.sv */
// Shared constants, types and helpers for the point perspective projection block.
`default_nettype none
package ppp_pkg;
   localparam int SCREEN_WIDTH  = 800;
   localparam int SCREEN_HEIGHT = 600;

   localparam int FIX_W      = 32;
   localparam int PAIR_W     = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CAM_W      = 50;
   localparam int MAG_W      = CAM_W - 1;
   localparam int SCALE_W    = $clog2(((SCREEN_WIDTH > SCREEN_HEIGHT) ?
                                       SCREEN_WIDTH : SCREEN_HEIGHT) + 1);
   localparam int PROD_W     = MAG_W + SCALE_W;
   localparam int SPLIT_W    = 30;
   localparam int HI_W       = PROD_W - SPLIT_W;
   localparam int NUM_W      = PROD_W + FIX_W + 1;
   localparam int DEN_W      = CAM_W;
   localparam int QUO_W      = 34;
   localparam int TOP_W      = NUM_W - QUO_W;
   localparam int QSUM_W     = QUO_W + 3;
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = $clog2(QDEPTH + 1);
   localparam int NEAR_LIMIT = 65;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW0_FIRST  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW0_SECOND = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1_FIRST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1_SECOND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2_FIRST  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2_SECOND = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL       = 3'd6;

   typedef logic signed [CAM_W-1:0] cam_type;

   typedef struct packed {
      logic [PAIR_W-1:0] row0_first;
      logic [PAIR_W-1:0] row0_second;
      logic [PAIR_W-1:0] row1_first;
      logic [PAIR_W-1:0] row1_second;
      logic [PAIR_W-1:0] row2_first;
      logic [PAIR_W-1:0] row2_second;
   } matrix_type;

   typedef struct packed {
      cam_type cx;
      cam_type cy;
      cam_type cz;
   } entry_type;

   typedef struct packed {
      logic             visible;
      logic             neg_x;
      logic             neg_y;
      logic [FIX_W-1:0] depth;
   } tag_type;

   function automatic logic [FIX_W-1:0] sat_cam(input cam_type v);
      logic [FIX_W-1:0] r;
      if (v > cam_type'(64'sd2147483647)) r = 32'h7fff_ffff;
      else if (v < cam_type'(-64'sd2147483648)) r = 32'h8000_0000;
      else r = v[FIX_W-1:0];
      return r;
   endfunction

   function automatic logic [FIX_W-1:0] sat_screen(input logic signed [QSUM_W-1:0] v);
      logic [FIX_W-1:0] r;
      if (v > QSUM_W'(64'sd2147483647)) r = 32'h7fff_ffff;
      else if (v < QSUM_W'(-64'sd2147483648)) r = 32'h8000_0000;
      else r = v[FIX_W-1:0];
      return r;
   endfunction
endpackage
`default_nettype wire

/* rtl/ppp_front.sv */
// Front end: accepts points and forms camera-space coordinates.
`default_nettype none
module ppp_front
   import ppp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire matrix_type               matrix,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [FIX_W-1:0]  req_point_x,
   input  wire logic signed [FIX_W-1:0]  req_point_y,
   input  wire logic signed [FIX_W-1:0]  req_point_z,
   input  wire logic [QCNT_W-1:0]        queue_count,
   output logic                          push,
   output entry_type                     push_entry
);
   logic                        v1_ff, v2_ff;
   logic signed [63:0]          prod_ff [9];
   logic signed [63:0]          prod_in [9];
   logic signed [FIX_W-1:0]     trans_ff [3];
   logic signed [FIX_W-1:0]     coef [9];
   logic signed [FIX_W-1:0]     trans_in [3];
   logic signed [FIX_W-1:0]     pt [3];
   logic signed [65:0]          row_sum [3];
   logic signed [65:0]          row_shift [3];
   cam_type                     cam_in [3];
   entry_type                   entry_ff;
   logic [QCNT_W:0]             occupancy;
   logic                        accept;

   assign occupancy = {1'b0, queue_count} + {{QCNT_W{1'b0}}, v1_ff}
                      + {{QCNT_W{1'b0}}, v2_ff};
   assign req_stall = (occupancy >= (QCNT_W + 1)'(QDEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      coef[0] = matrix.row0_first[63:32];
      coef[1] = matrix.row0_first[31:0];
      coef[2] = matrix.row0_second[63:32];
      coef[3] = matrix.row1_first[63:32];
      coef[4] = matrix.row1_first[31:0];
      coef[5] = matrix.row1_second[63:32];
      coef[6] = matrix.row2_first[63:32];
      coef[7] = matrix.row2_first[31:0];
      coef[8] = matrix.row2_second[63:32];
      trans_in[0] = matrix.row0_second[31:0];
      trans_in[1] = matrix.row1_second[31:0];
      trans_in[2] = matrix.row2_second[31:0];
      pt[0] = req_point_x;
      pt[1] = req_point_y;
      pt[2] = req_point_z;
      for (int i = 0; i < 9; i++) begin
         prod_in[i] = 64'(coef[i]) * 64'(pt[i % 3]);
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_sum[r]   = 66'(prod_ff[3*r]) + 66'(prod_ff[3*r+1]) + 66'(prod_ff[3*r+2])
                        + 66'sd32768;
         row_shift[r] = row_sum[r] >>> 16;
         cam_in[r]    = cam_type'(row_shift[r]) + cam_type'(trans_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) prod_ff[i] <= prod_in[i];
      for (int r = 0; r < 3; r++) trans_ff[r] <= trans_in[r];
      entry_ff.cx <= cam_in[0];
      entry_ff.cy <= cam_in[1];
      entry_ff.cz <= cam_in[2];
   end

   assign push       = v2_ff;
   assign push_entry = entry_ff;

   assert property (@(posedge clock) disable iff (reset) accept |=> v1_ff)
      else $error("accepted transaction did not enter the front stage");
endmodule
`default_nettype wire

/* rtl/ppp_queue.sv */
// Short queue between the front end and the projection back end.
`default_nettype none
module ppp_queue
   import ppp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire entry_type          push_entry,
   input  wire logic               pop,
   output logic                    pop_valid,
   output entry_type               pop_entry,
   output logic [QCNT_W-1:0]       count
);
   entry_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]     wr_ff, rd_ff;
   logic [QCNT_W-1:0]     count_ff;
   logic                  do_pop;

   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ff];
   assign count     = count_ff;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         if (push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (!push && do_pop) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_entry;
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < QCNT_W'(QDEPTH)) || do_pop)
      else $error("push into full queue");
endmodule
`default_nettype wire

/* rtl/ppp_div.sv */
// Pipelined restoring divider for the x and y lanes with a shared divisor.
`default_nettype none
module ppp_div
   import ppp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire tag_type            in_tag,
   input  wire logic [NUM_W-1:0]   num_x,
   input  wire logic [NUM_W-1:0]   num_y,
   input  wire logic [DEN_W-1:0]   den,
   output logic                    out_valid,
   output tag_type                 out_tag,
   output logic [QUO_W-1:0]        quo_x,
   output logic [QUO_W-1:0]        quo_y,
   output logic                    ovf_x,
   output logic                    ovf_y
);
   localparam int NST = QUO_W + 1;

   logic                valid_ff [NST];
   tag_type             tag_ff   [NST];
   logic [DEN_W-1:0]    den_ff   [NST];
   logic [DEN_W-1:0]    rem_ff   [2][NST];
   logic [QUO_W-1:0]    low_ff   [2][NST];
   logic [QUO_W-1:0]    quo_ff   [2][NST];
   logic                ovf_ff   [2][NST];

   logic [DEN_W-1:0]    rem_in   [2][NST];
   logic [QUO_W-1:0]    low_in   [2][NST];
   logic [QUO_W-1:0]    quo_in   [2][NST];
   logic                ovf_in   [2][NST];
   logic [DEN_W:0]      trial    [2][NST];
   logic [DEN_W:0]      diff     [2][NST];
   logic [NUM_W-1:0]    num      [2];
   logic [TOP_W-1:0]    top      [2];

   always_comb begin
      num[0] = num_x;
      num[1] = num_y;
      for (int l = 0; l < 2; l++) begin
         top[l]       = num[l][NUM_W-1:QUO_W];
         ovf_in[l][0] = (top[l] >= TOP_W'(den));
         rem_in[l][0] = top[l][DEN_W-1:0];
         low_in[l][0] = num[l][QUO_W-1:0];
         quo_in[l][0] = '0;
         trial[l][0]  = '0;
         diff[l][0]   = '0;
         for (int k = 1; k < NST; k++) begin
            trial[l][k]  = {rem_ff[l][k-1], low_ff[l][k-1][QUO_W-1]};
            diff[l][k]   = trial[l][k] - {1'b0, den_ff[k-1]};
            low_in[l][k] = {low_ff[l][k-1][QUO_W-2:0], 1'b0};
            ovf_in[l][k] = ovf_ff[l][k-1];
            if (trial[l][k] >= {1'b0, den_ff[k-1]}) begin
               rem_in[l][k] = diff[l][k][DEN_W-1:0];
               quo_in[l][k] = {quo_ff[l][k-1][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[l][k] = trial[l][k][DEN_W-1:0];
               quo_in[l][k] = {quo_ff[l][k-1][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < NST; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         den_ff[0] <= den;
         for (int k = 1; k < NST; k++) begin
            tag_ff[k] <= tag_ff[k-1];
            den_ff[k] <= den_ff[k-1];
         end
         for (int l = 0; l < 2; l++) begin
            for (int k = 0; k < NST; k++) begin
               rem_ff[l][k] <= rem_in[l][k];
               low_ff[l][k] <= low_in[l][k];
               quo_ff[l][k] <= quo_in[l][k];
               ovf_ff[l][k] <= ovf_in[l][k];
            end
         end
      end
   end

   assign out_valid = valid_ff[NST-1];
   assign out_tag   = tag_ff[NST-1];
   assign quo_x     = quo_ff[0][NST-1];
   assign quo_y     = quo_ff[1][NST-1];
   assign ovf_x     = ovf_ff[0][NST-1];
   assign ovf_y     = ovf_ff[1][NST-1];
endmodule
`default_nettype wire

/* rtl/ppp_back.sv */
// Back end: perspective divide, focal scaling, viewport mapping and result register.
`default_nettype none
module ppp_back
   import ppp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [FIX_W-1:0]   focal,
   input  wire logic               in_valid,
   input  wire entry_type          in_entry,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_visible,
   output logic signed [FIX_W-1:0] rsp_screen_x,
   output logic signed [FIX_W-1:0] rsp_screen_y,
   output logic signed [FIX_W-1:0] rsp_camera_depth
);
   localparam logic signed [QSUM_W-1:0] BASE_X = QSUM_W'(SCREEN_WIDTH * 32768);
   localparam logic signed [QSUM_W-1:0] BASE_Y = QSUM_W'(SCREEN_HEIGHT * 32768);

   logic                     en;
   logic                     s1_ff, s2_ff, s3_ff;
   tag_type                  tag1_ff, tag2_ff, tag3_ff, tag1_in;
   cam_type                  cz1_ff, cz2_ff;
   logic [PROD_W-1:0]        mx_ff, my_ff, mx_in, my_in;
   logic [MAG_W-1:0]         mag_x, mag_y;
   cam_type                  neg_cx, neg_cy;
   logic [SPLIT_W+FIX_W-1:0] plo_x_ff, plo_y_ff;
   logic [HI_W+FIX_W-1:0]    phi_x_ff, phi_y_ff;
   logic [NUM_W-1:0]         nx_ff, ny_ff, nx_in, ny_in;
   logic [DEN_W-1:0]         den_ff;
   logic                     d_valid, d_ovf_x, d_ovf_y;
   tag_type                  d_tag;
   logic [QUO_W-1:0]         d_quo_x, d_quo_y;
   logic [QUO_W:0]           qc_x, qc_y;
   logic signed [QSUM_W-1:0] qs_x, qs_y, sx, sy;
   logic                     rsp_valid_ff, vis_ff;
   logic [FIX_W-1:0]         sx_ff, sy_ff, depth_ff;

   assign en  = !rsp_valid_ff || !rsp_stall;
   assign pop = en && in_valid;

   always_comb begin
      neg_cx = -in_entry.cx;
      neg_cy = -in_entry.cy;
      mag_x  = in_entry.cx[CAM_W-1] ? neg_cx[MAG_W-1:0] : in_entry.cx[MAG_W-1:0];
      mag_y  = in_entry.cy[CAM_W-1] ? neg_cy[MAG_W-1:0] : in_entry.cy[MAG_W-1:0];
      mx_in  = PROD_W'(mag_x) * PROD_W'(SCREEN_WIDTH);
      my_in  = PROD_W'(mag_y) * PROD_W'(SCREEN_HEIGHT);
      tag1_in.visible = (in_entry.cz > cam_type'(NEAR_LIMIT));
      tag1_in.neg_x   = in_entry.cx[CAM_W-1];
      tag1_in.neg_y   = in_entry.cy[CAM_W-1];
      tag1_in.depth   = sat_cam(in_entry.cz);
   end

   assign nx_in = NUM_W'(plo_x_ff) + (NUM_W'(phi_x_ff) << SPLIT_W)
                  + NUM_W'(cz2_ff[CAM_W-2:0]);
   assign ny_in = NUM_W'(plo_y_ff) + (NUM_W'(phi_y_ff) << SPLIT_W)
                  + NUM_W'(cz2_ff[CAM_W-2:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
         s3_ff <= 1'b0;
      end else if (en) begin
         s1_ff <= in_valid;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff    <= mx_in;
         my_ff    <= my_in;
         cz1_ff   <= in_entry.cz;
         tag1_ff  <= tag1_in;
         plo_x_ff <= (SPLIT_W+FIX_W)'(mx_ff[SPLIT_W-1:0]) * (SPLIT_W+FIX_W)'(focal);
         plo_y_ff <= (SPLIT_W+FIX_W)'(my_ff[SPLIT_W-1:0]) * (SPLIT_W+FIX_W)'(focal);
         phi_x_ff <= (HI_W+FIX_W)'(mx_ff[PROD_W-1:SPLIT_W]) * (HI_W+FIX_W)'(focal);
         phi_y_ff <= (HI_W+FIX_W)'(my_ff[PROD_W-1:SPLIT_W]) * (HI_W+FIX_W)'(focal);
         cz2_ff   <= cz1_ff;
         tag2_ff  <= tag1_ff;
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
         den_ff   <= {cz2_ff[CAM_W-2:0], 1'b0};
         tag3_ff  <= tag2_ff;
      end
   end

   ppp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_ff),
      .in_tag    (tag3_ff),
      .num_x     (nx_ff),
      .num_y     (ny_ff),
      .den       (den_ff),
      .out_valid (d_valid),
      .out_tag   (d_tag),
      .quo_x     (d_quo_x),
      .quo_y     (d_quo_y),
      .ovf_x     (d_ovf_x),
      .ovf_y     (d_ovf_y)
   );

   always_comb begin
      qc_x = d_ovf_x ? ((QUO_W + 1)'(1) << QUO_W) : {1'b0, d_quo_x};
      qc_y = d_ovf_y ? ((QUO_W + 1)'(1) << QUO_W) : {1'b0, d_quo_y};
      qs_x = $signed(QSUM_W'(qc_x));
      qs_y = $signed(QSUM_W'(qc_y));
      sx   = d_tag.neg_x ? (BASE_X - qs_x) : (BASE_X + qs_x);
      sy   = d_tag.neg_y ? (BASE_Y + qs_y) : (BASE_Y - qs_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vis_ff   <= d_tag.visible;
         sx_ff    <= d_tag.visible ? sat_screen(sx) : '0;
         sy_ff    <= d_tag.visible ? sat_screen(sy) : '0;
         depth_ff <= d_tag.depth;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_visible      = vis_ff;
   assign rsp_screen_x     = sx_ff;
   assign rsp_screen_y     = sy_ff;
   assign rsp_camera_depth = depth_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !vis_ff |-> (sx_ff == '0) && (sy_ff == '0))
      else $error("invisible point with nonzero screen position");
   assert property (@(posedge clock) disable iff (reset)
      pop |-> in_valid && en)
      else $error("queue popped while back end held");
endmodule
`default_nettype wire

/* rtl/point_perspective_projection.sv */
// Top level of the point perspective projection block with its register file.
// Usage:
//   req_* channel takes one world point (signed Q16.16 x, y, z) per transaction;
//   a transaction is taken when req_valid is high and req_stall is low.
//   rsp_* channel returns one result per point, in order: visible flag,
//   screen x and y in signed Q16.16 pixels, and camera depth. A result is
//   taken when rsp_valid is high and rsp_stall is low.
//   csr_* channel writes the view matrix rows and the focal length; csr_ready
//   is always high. Write only while no transaction is in flight.
// Timing:
//   One point per cycle sustained while rsp_stall is low. From acceptance to
//   rsp_valid a point passes two front stages (products, row sums), the queue,
//   three scaling stages, 35 divider stages and the result register. The divider
//   forms one quotient bit per stage.
// Reset: clears all valid state and loads identity rows and focal 1.2.
// Stall: rsp_stall holds the result and freezes the back end while rsp_valid is high;
//   the front end keeps accepting until the queue and the two front stages
//   together hold four transactions, then raises req_stall.
`default_nettype none
module point_perspective_projection
   import ppp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [FIX_W-1:0]  req_point_x,
   input  wire logic signed [FIX_W-1:0]  req_point_y,
   input  wire logic signed [FIX_W-1:0]  req_point_z,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_visible,
   output logic signed [FIX_W-1:0]       rsp_screen_x,
   output logic signed [FIX_W-1:0]       rsp_screen_y,
   output logic signed [FIX_W-1:0]       rsp_camera_depth,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [PAIR_W-1:0]        csr_data
);
   matrix_type           matrix_ff;
   logic [FIX_W-1:0]     focal_ff;
   logic                 push, pop, pop_valid;
   entry_type            push_entry, pop_entry;
   logic [QCNT_W-1:0]    queue_count;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff.row0_first  <= 64'h0001_0000_0000_0000;
         matrix_ff.row0_second <= 64'h0;
         matrix_ff.row1_first  <= 64'h0000_0000_0001_0000;
         matrix_ff.row1_second <= 64'h0;
         matrix_ff.row2_first  <= 64'h0;
         matrix_ff.row2_second <= 64'h0001_0000_0000_0000;
         focal_ff              <= 32'd78643;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROW0_FIRST:  matrix_ff.row0_first  <= csr_data;
            CSR_ROW0_SECOND: matrix_ff.row0_second <= csr_data;
            CSR_ROW1_FIRST:  matrix_ff.row1_first  <= csr_data;
            CSR_ROW1_SECOND: matrix_ff.row1_second <= csr_data;
            CSR_ROW2_FIRST:  matrix_ff.row2_first  <= csr_data;
            CSR_ROW2_SECOND: matrix_ff.row2_second <= csr_data;
            CSR_FOCAL:       focal_ff              <= csr_data[FIX_W-1:0];
            default: ;
         endcase
      end
   end

   ppp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .matrix      (matrix_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .queue_count (queue_count),
      .push        (push),
      .push_entry  (push_entry)
   );

   ppp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .count      (queue_count)
   );

   ppp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .focal            (focal_ff),
      .in_valid         (pop_valid),
      .in_entry         (pop_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_visible      (rsp_visible),
      .rsp_screen_x     (rsp_screen_x),
      .rsp_screen_y     (rsp_screen_y),
      .rsp_camera_depth (rsp_camera_depth)
   );
endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the point perspective projection block.
`timescale 1ns / 1ps
`default_nettype none
module tb
   import ppp_pkg::*;
();

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 200;
   localparam int LONG_HOLD_AT = 300;
   localparam int LONG_HOLD_CYCLES = 400;

   typedef struct packed {
      logic             visible;
      logic [FIX_W-1:0] screen_x;
      logic [FIX_W-1:0] screen_y;
      logic [FIX_W-1:0] depth;
   } proj_type;

   typedef struct {
      logic signed [FIX_W-1:0] x;
      logic signed [FIX_W-1:0] y;
      logic signed [FIX_W-1:0] z;
      bit                      typed;
      proj_type                want;
   } point_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [FIX_W-1:0] req_point_x = '0;
   logic signed [FIX_W-1:0] req_point_y = '0;
   logic signed [FIX_W-1:0] req_point_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_visible;
   logic signed [FIX_W-1:0] rsp_screen_x;
   logic signed [FIX_W-1:0] rsp_screen_y;
   logic signed [FIX_W-1:0] rsp_camera_depth;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [PAIR_W-1:0] csr_data = '0;

   logic [PAIR_W-1:0] view_rows [6];
   logic [FIX_W-1:0]  focal;
   proj_type          pending_proj [$];
   int                failures = 0;
   int                received = 0;
   bit                burst = 1'b0;

   point_perspective_projection uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #5000000;
      $display("tb NOT OK");
      $finish;
   end

   function automatic logic signed [63:0] row_sum(input logic [PAIR_W-1:0] fp, sp,
                                                  input logic signed [FIX_W-1:0] x, y, z);
      logic signed [79:0] acc;
      acc = $signed(fp[63:32]) * x + $signed(fp[31:0]) * y + $signed(sp[63:32]) * z;
      acc = acc + ($signed({{48{sp[31]}}, sp[31:0]}) <<< 16) + 80'sd32768;
      return 64'(acc >>> 16);
   endfunction

   function automatic logic signed [63:0] project_term(input logic signed [63:0] c, cz,
                                                       input int unsigned scale);
      logic [127:0] mag, num, den, q;
      mag = 128'(c < 0 ? -c : c);
      den = 128'(cz) * 2;
      num = mag * scale * focal + (den >> 1);
      q = num / den;
      if (q > (128'd1 << 40)) q = 128'd1 << 40;
      return c < 0 ? -64'(q) : 64'(q);
   endfunction

   function automatic logic [FIX_W-1:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[FIX_W-1:0];
   endfunction

   function automatic proj_type project_point(input logic signed [FIX_W-1:0] x, y, z);
      logic signed [63:0] cx, cy, cz;
      proj_type r;
      cx = row_sum(view_rows[0], view_rows[1], x, y, z);
      cy = row_sum(view_rows[2], view_rows[3], x, y, z);
      cz = row_sum(view_rows[4], view_rows[5], x, y, z);
      r = '0;
      r.depth = clamp32(cz);
      if (cz > NEAR_LIMIT) begin
         r.visible = 1'b1;
         r.screen_x = clamp32(64'(SCREEN_WIDTH) * 32768 + project_term(cx, cz, SCREEN_WIDTH));
         r.screen_y = clamp32(64'(SCREEN_HEIGHT) * 32768 - project_term(cy, cz, SCREEN_HEIGHT));
      end
      return r;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [PAIR_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_FOCAL) focal = data[FIX_W-1:0];
      else if (idx != CSR_UNMAPPED) view_rows[idx] = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_point(input logic signed [FIX_W-1:0] x, y, z,
                             input bit typed, input proj_type want);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 19);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      do @(posedge clock); while (req_stall);
      pending_proj.insert(pending_proj.size(), typed ? want : project_point(x, y, z));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_proj.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   function automatic logic [FIX_W-1:0] coef();
      return FIX_W'($urandom_range(0, 262143)) - 32'd131072;
   endfunction

   function automatic logic signed [FIX_W-1:0] coord();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return FIX_W'($urandom_range(0, 2097151)) - 32'd1048576;
   endfunction

   // receive side: random stall, one long hold-off, compare in order
   initial begin
      int n;
      proj_type want;
      forever begin
         n = burst ? 0 : $urandom_range(0, 19);
         if (received == LONG_HOLD_AT) n = LONG_HOLD_CYCLES;
         repeat (n) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid || reset);
         received++;
         if (pending_proj.size() == 0) begin
            $error("unexpected result transaction");
            failures++;
         end else begin
            want = pending_proj.pop_front();
            if (rsp_visible !== want.visible) begin
               $error("visible: expected %0d, got %0d", want.visible, rsp_visible);
               failures++;
            end
            if (rsp_screen_x !== want.screen_x) begin
               $error("screen_x: expected %h, got %h", want.screen_x, rsp_screen_x);
               failures++;
            end
            if (rsp_screen_y !== want.screen_y) begin
               $error("screen_y: expected %h, got %h", want.screen_y, rsp_screen_y);
               failures++;
            end
            if (rsp_camera_depth !== want.depth) begin
               $error("camera_depth: expected %h, got %h", want.depth, rsp_camera_depth);
               failures++;
            end
         end
      end
   end

   initial begin
      point_row_type dir_rows [12];
      logic [PAIR_W-1:0] t2;
      dir_rows = '{
         '{32'sd0, 32'sd0, 32'sd65536, 1, '{1'b1, 32'd26214400, 32'd19660800, 32'd65536}},
         '{32'sd0, 32'sd0, 32'sd0, 1, '{1'b0, 32'd0, 32'd0, 32'd0}},
         '{32'sd0, 32'sd0, 32'sd65, 1, '{1'b0, 32'd0, 32'd0, 32'd65}},
         '{32'sd0, 32'sd0, 32'sd66, 0, '0},
         '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, '0},
         '{32'h80000000, 32'h80000000, 32'h80000000, 1, '{1'b0, 32'd0, 32'd0, 32'h80000000}},
         '{32'sd65536, -32'sd65536, 32'sd65536, 0, '0},
         '{32'h7fffffff, 32'h80000000, 32'sd66, 0, '0},
         '{32'h80000000, 32'h7fffffff, 32'sd66, 0, '0},
         '{32'sd0, 32'sd0, -32'sd1, 1, '{1'b0, 32'd0, 32'd0, 32'hffffffff}},
         '{32'sd1, 32'sd1, 32'sd1, 0, '0},
         '{32'h55555555, 32'haaaaaaaa, 32'h40000000, 0, '0}
      };
      view_rows = '{64'h0001_0000_0000_0000, 64'd0, 64'h0000_0000_0001_0000, 64'd0,
                    64'd0, 64'h0001_0000_0000_0000};
      focal = 32'd78643;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i])
         send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].typed,
                    dir_rows[i].want);
      for (int p = 0; p < PHASES; p++) begin
         drain();
         if (p == 0) begin
            for (int r = 0; r <= CSR_UNMAPPED; r++) write_reg(CSR_IDX_W'(r), '1);
         end else if (p == 1) begin
            write_reg(CSR_ROW0_FIRST, '0);
            write_reg(CSR_ROW0_SECOND, '0);
            write_reg(CSR_ROW1_FIRST, '0);
            write_reg(CSR_ROW1_SECOND, '0);
            write_reg(CSR_ROW2_FIRST, '0);
            write_reg(CSR_ROW2_SECOND, 64'h0001_0000_7fff_ffff);
            write_reg(CSR_FOCAL, '0);
         end else if (p == 2) begin
            write_reg(CSR_ROW0_FIRST, 64'h7fff_ffff_8000_0000);
            write_reg(CSR_ROW1_FIRST, 64'h8000_0000_7fff_ffff);
            write_reg(CSR_ROW2_SECOND, 64'h0000_0001_0000_0042);
            write_reg(CSR_FOCAL, 64'hffff_ffff_ffff_ffff);
         end else begin
            t2 = {32'd0, $urandom_range(0, 1 << 22)};
            write_reg(CSR_ROW0_FIRST, {coef(), coef()});
            write_reg(CSR_ROW0_SECOND, {coef(), coef()});
            write_reg(CSR_ROW1_FIRST, {coef(), coef()});
            write_reg(CSR_ROW1_SECOND, {coef(), coef()});
            write_reg(CSR_ROW2_FIRST, {coef(), coef()});
            write_reg(CSR_ROW2_SECOND, p == 7 ? {$urandom, $urandom} : {coef(), t2[31:0]});
            write_reg(CSR_FOCAL, {$urandom, 32'($urandom_range(16384, 262144))});
            write_reg(CSR_UNMAPPED, {$urandom, $urandom});
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
            send_point(coord(), coord(), coord(), 1'b0, '0);
         end
      end
      burst = 1'b0;
      drain();
      if (failures == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end
endmodule
`default_nettype wire
